>>> design/jh2d_pkg.sv
// Package for the joint histogram block: widths, opcodes, register indexes, queue entry type.
// No dependencies.
package jh2d_pkg;
  localparam int MAX_BINS    = 64;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int ADDR_W      = 2 * BIN_W;
  localparam int DEPTH       = MAX_BINS * MAX_BINS;
  localparam int VALUE_WIDTH = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int OFF_W       = VALUE_WIDTH + 1;
  localparam int NUM_W       = OFF_W + 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] REG_FIRST_MIN   = 3'd0;
  localparam logic [2:0] REG_FIRST_MAX   = 3'd1;
  localparam logic [2:0] REG_SECOND_MIN  = 3'd2;
  localparam logic [2:0] REG_SECOND_MAX  = 3'd3;
  localparam logic [2:0] REG_FIRST_BINS  = 3'd4;
  localparam logic [2:0] REG_SECOND_BINS = 3'd5;
  localparam logic [2:0] REG_CLIP_EN     = 3'd6;
  localparam logic [2:0] REG_MAX_PER_BIN = 3'd7;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_INC  = 2'd0,
    CMD_READ = 2'd1,
    CMD_CLR  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
  } qent_t;
endpackage

>>> design/joint_histogram_2d.sv
// Joint 2-D histogram of paired samples with optional per-bin clipping.
// Sample: binned one axis after the other by the shared bit-serial divider in the front end.
// Read: via the queue, B_RD and B_WB to out_tvalid; clear: a sweep of the count memory.
// Throughput: one word at a time in the front end; the back end works behind a queue.
// Reset (rst_n low, synchronous) restores registers, then a clearing sweep of
// the count memory runs; words wait in the queue until it is done.
module joint_histogram_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: opcode[1:0], first_value[17:2], second_value[33:18],
  // read_first_bin[39:34], read_second_bin[45:40], zero pad to 48
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: bin_count[31:0]
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [jh2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jh2d_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jh2d_pkg::*;

  logic [VALUE_WIDTH-1:0] fmin_r, fmax_r, smin_r, smax_r;
  logic [6:0]             fbins_r, sbins_r;
  logic                   clip_r;
  logic [COUNT_WIDTH-1:0] mpb_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmin_r <= '0; fmax_r <= 16'd255; smin_r <= '0; smax_r <= 16'd255;
      fbins_r <= 7'd64; sbins_r <= 7'd64; clip_r <= 1'b0; mpb_r <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIRST_MIN:   fmin_r  <= cfg_data[VALUE_WIDTH-1:0];
        REG_FIRST_MAX:   fmax_r  <= cfg_data[VALUE_WIDTH-1:0];
        REG_SECOND_MIN:  smin_r  <= cfg_data[VALUE_WIDTH-1:0];
        REG_SECOND_MAX:  smax_r  <= cfg_data[VALUE_WIDTH-1:0];
        REG_FIRST_BINS:  fbins_r <= cfg_data[6:0];
        REG_SECOND_BINS: sbins_r <= cfg_data[6:0];
        REG_CLIP_EN:     clip_r  <= cfg_data[0];
        REG_MAX_PER_BIN: mpb_r   <= cfg_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic  q_push, q_full, q_pop, q_empty;
  qent_t q_wdata, q_rdata;

  jh2d_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .opcode(in_tdata[1:0]), .first_value(in_tdata[17:2]), .second_value(in_tdata[33:18]),
    .rd_first(in_tdata[39:34]), .rd_second(in_tdata[45:40]),
    .first_min(fmin_r), .first_max(fmax_r), .second_min(smin_r), .second_max(smax_r),
    .first_bins(fbins_r), .second_bins(sbins_r),
    .q_push, .q_data(q_wdata), .q_full
  );

  jh2d_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  jh2d_back u_back (
    .clk, .rst_n, .q_empty, .q_data(q_rdata), .q_pop,
    .clip_enable(clip_r), .max_per_bin(mpb_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .bin_count(out_tdata)
  );
endmodule

>>> design/jh2d_front.sv
// Front end: accepts words, bins samples with a shared restoring divider.
// Depends on jh2d_pkg.
module jh2d_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [jh2d_pkg::VALUE_WIDTH-1:0] first_value,
  input  logic [jh2d_pkg::VALUE_WIDTH-1:0] second_value,
  input  logic [jh2d_pkg::BIN_W-1:0]    rd_first,
  input  logic [jh2d_pkg::BIN_W-1:0]    rd_second,
  input  logic [jh2d_pkg::VALUE_WIDTH-1:0] first_min,
  input  logic [jh2d_pkg::VALUE_WIDTH-1:0] first_max,
  input  logic [jh2d_pkg::VALUE_WIDTH-1:0] second_min,
  input  logic [jh2d_pkg::VALUE_WIDTH-1:0] second_max,
  input  logic [6:0]                    first_bins,
  input  logic [6:0]                    second_bins,
  output logic                          q_push,
  output jh2d_pkg::qent_t               q_data,
  input  logic                          q_full
);
  import jh2d_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_NEXT = 4'b0100,
    S_PUSH = 4'b1000
  } fst_t;

  fst_t              st_r, st_nxt;
  logic              axis_r;               // 0 first, 1 second
  logic [NUM_W-1:0]  num_r;                // numerator, shifted into quotient
  logic [OFF_W-1:0]  rem_r, den_r;
  logic [OFF_W-1:0]  off2_r, den2_r;
  logic [6:0]        bins2_r;
  logic [$clog2(NUM_W+1)-1:0] cnt_r;
  logic [BIN_W-1:0]  b1_r;
  qent_t             ent_r;

  function automatic logic [6:0] eff(input logic [6:0] b);
    if (b == 7'd0) return 7'd1;
    if (b > 7'(MAX_BINS)) return 7'(MAX_BINS);
    return b;
  endfunction

  logic signed [OFF_W-1:0] v1, v2, lo1, hi1, lo2, hi2;
  logic ok1, ok2;
  logic [OFF_W-1:0] o1, o2, d1, d2;
  logic [OFF_W:0]   trial;

  always_comb begin
    v1  = OFF_W'(signed'(first_value));
    v2  = OFF_W'(signed'(second_value));
    lo1 = OFF_W'(signed'(first_min));
    hi1 = OFF_W'(signed'(first_max));
    lo2 = OFF_W'(signed'(second_min));
    hi2 = OFF_W'(signed'(second_max));
    ok1 = (hi1 >= lo1) && (v1 >= lo1) && (v1 <= hi1);
    ok2 = (hi2 >= lo2) && (v2 >= lo2) && (v2 <= hi2);
    o1  = OFF_W'(v1 - lo1);
    o2  = OFF_W'(v2 - lo2);
    d1  = OFF_W'(hi1 - lo1) + OFF_W'(1);
    d2  = OFF_W'(hi2 - lo2) + OFF_W'(1);
    trial = {rem_r, num_r[NUM_W-1]} - {1'b0, den_r};
  end

  assign in_ready = (st_r == S_IDLE);
  assign q_push   = (st_r == S_PUSH) && !q_full;
  assign q_data   = ent_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        if (opcode == OP_SAMPLE) st_nxt = (ok1 && ok2) ? S_DIV : S_IDLE;
        else if (opcode == OP_READ || opcode == OP_CLEAR) st_nxt = S_PUSH;
      end
      S_DIV:  if (cnt_r == ($clog2(NUM_W+1))'(NUM_W - 1)) st_nxt = axis_r ? S_PUSH : S_NEXT;
      S_NEXT: st_nxt = S_DIV;
      S_PUSH: if (!q_full) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
    unique case (st_r)
      S_IDLE: begin
        axis_r  <= 1'b0;
        cnt_r   <= '0;
        rem_r   <= '0;
        num_r   <= NUM_W'(o1) * NUM_W'(eff(first_bins));
        den_r   <= d1;
        off2_r  <= o2;
        den2_r  <= d2;
        bins2_r <= eff(second_bins);
        ent_r.cmd  <= (opcode == OP_READ) ? CMD_READ : CMD_CLR;
        ent_r.addr <= {rd_second, rd_first};
      end
      S_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (!trial[OFF_W]) begin
          rem_r <= trial[OFF_W-1:0];
          num_r <= {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[OFF_W-2:0], num_r[NUM_W-1]};
          num_r <= {num_r[NUM_W-2:0], 1'b0};
        end
        if (cnt_r == ($clog2(NUM_W+1))'(NUM_W - 1) && axis_r) begin
          ent_r.cmd  <= CMD_INC;
          ent_r.addr <= {(!trial[OFF_W] ? {num_r[BIN_W-2:0], 1'b1}
                                        : {num_r[BIN_W-2:0], 1'b0}), b1_r};
        end
        if (cnt_r == ($clog2(NUM_W+1))'(NUM_W - 1) && !axis_r)
          b1_r <= !trial[OFF_W] ? {num_r[BIN_W-2:0], 1'b1} : {num_r[BIN_W-2:0], 1'b0};
      end
      S_NEXT: begin
        axis_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        num_r  <= NUM_W'(off2_r) * NUM_W'(bins2_r);
        den_r  <= den2_r;
      end
      S_PUSH: ;
      default: ;
    endcase
  end
endmodule

>>> design/jh2d_queue.sv
// Two-entry queue between front and back ends.
// Depends on jh2d_pkg.
module jh2d_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jh2d_pkg::qent_t wdata,
  output logic            full,
  input  logic            pop,
  output jh2d_pkg::qent_t rdata,
  output logic            empty
);
  import jh2d_pkg::*;
  qent_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] n_r;

  assign full  = (n_r == 2'd2);
  assign empty = (n_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; n_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      n_r <= n_r + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> design/jh2d_back.sv
// Back end: count memory with read-modify-write, clearing sweep and output register.
// Depends on jh2d_pkg.
module jh2d_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  jh2d_pkg::qent_t q_data,
  output logic            q_pop,
  input  logic            clip_enable,
  input  logic [jh2d_pkg::COUNT_WIDTH-1:0] max_per_bin,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [jh2d_pkg::COUNT_WIDTH-1:0] bin_count
);
  import jh2d_pkg::*;

  typedef enum logic [3:0] {
    B_CLR  = 4'b0001,
    B_IDLE = 4'b0010,
    B_RD   = 4'b0100,
    B_WB   = 4'b1000
  } bst_t;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_r;
  logic [ADDR_W-1:0]      addr_r, clr_r;
  cmd_t                   cmd_r;
  bst_t                   st_r;
  logic                   ov_r;

  logic rd_busy;
  assign rd_busy = (ov_r && !out_ready);
  assign q_pop = (st_r == B_IDLE) && !q_empty &&
                 !(q_data.cmd == CMD_READ && rd_busy);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (q_pop) rd_r <= mem[q_data.addr];
    if (st_r == B_CLR) mem[clr_r] <= '0;
    if (st_r == B_WB && cmd_r == CMD_INC &&
        !(clip_enable && rd_r >= max_per_bin) && rd_r != '1)
      mem[addr_r] <= rd_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin addr_r <= q_data.addr; cmd_r <= q_data.cmd; end
    if (st_r == B_WB && cmd_r == CMD_READ) bin_count <= rd_r;
    if (!rst_n) begin
      st_r <= B_CLR; clr_r <= '0; ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) st_r <= B_IDLE;
        end
        B_IDLE: if (q_pop) begin
          if (q_data.cmd == CMD_CLR) begin st_r <= B_CLR; clr_r <= '0; end
          else st_r <= B_RD;
        end
        B_RD: st_r <= B_WB;
        B_WB: begin
          if (cmd_r == CMD_READ) ov_r <= 1'b1;
          st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end
endmodule

>>> design/jh2d_checker.sv
// Port-level checks for the joint histogram block, bound to the top level.
// Depends on jh2d_pkg and the joint_histogram_2d ports.
module jh2d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import jh2d_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] == OP_READ || in_tdata[1:0] == OP_CLEAR)
    |=> !in_tready)
    else $error("front took two words back to back");
endmodule

bind joint_histogram_2d jh2d_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata
);
